// ===== hdl/uvs_pkg.sv =====
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared constants and types of the UV sphere vertex generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam logic [7:0] SLICES_RESET = 8'd48;

    // Q2.30 constants
    localparam logic [30:0] HALFPI_Q30 = 31'd1686629713;
    localparam logic [31:0] ONE_Q30    = 32'd1073741824;

    // series terms in the Taylor chain (cos to x^14, sin to x^13)
    localparam int TERMS = 7;

    // divider lanes
    localparam int LANES   = 4;
    localparam int LANE_POL = 0;
    localparam int LANE_AZ  = 1;
    localparam int LANE_TS  = 2;
    localparam int LANE_TT  = 3;

    // series index inside one angle
    localparam int SER_SIN = 0;
    localparam int SER_COS = 1;

    // angle index
    localparam int ANG_POL = 0;
    localparam int ANG_AZ  = 1;

    typedef struct packed {
        logic        oor;
        logic [1:0]  quad_pol;
        logic [1:0]  quad_az;
        logic [16:0] tex_s;
        logic [16:0] tex_t;
    } t_side;

endpackage

// ===== hdl/uvs_div_cell.sv =====
// ----------------------------------------------------------------------------
// uvs_div_cell
// One restoring-division step for all divider lanes: one quotient bit.
// ----------------------------------------------------------------------------
module uvs_div_cell
    import uvs_pkg::*;
#(
    parameter int NSTEP = 17
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_oor,
    input  logic [7:0]                       i_div,
    input  logic [LANES-1:0][7:0]            i_rem,
    input  logic [LANES-1:0][NSTEP-1:0]      i_dq,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_oor,
    output logic [7:0]                       o_div,
    output logic [LANES-1:0][7:0]            o_rem,
    output logic [LANES-1:0][NSTEP-1:0]      o_dq
);

    logic                        r_valid;
    logic                        r_oor;
    logic [7:0]                  r_div;
    logic [LANES-1:0][7:0]       r_rem;
    logic [LANES-1:0][NSTEP-1:0] r_dq;
    logic [LANES-1:0][7:0]       n_rem;
    logic [LANES-1:0][NSTEP-1:0] n_dq;
    logic                        rdy;

    always_comb begin
        logic [8:0] v_t;
        v_t = '0;
        for (int l = 0; l < LANES; l++) begin
            v_t = {i_rem[l], i_dq[l][NSTEP-1]};
            if (v_t >= {1'b0, i_div}) begin
                n_rem[l] = 8'(v_t - {1'b0, i_div});
                n_dq[l]  = {i_dq[l][NSTEP-2:0], 1'b1};
            end else begin
                n_rem[l] = v_t[7:0];
                n_dq[l]  = {i_dq[l][NSTEP-2:0], 1'b0};
            end
        end
    end

    assign rdy     = !r_valid || i_ready;
    assign o_ready = rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (rdy) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && rdy) begin
            r_oor <= i_oor;
            r_div <= i_div;
            r_rem <= n_rem;
            r_dq  <= n_dq;
        end
    end

    assign o_valid = r_valid;
    assign o_oor   = r_oor;
    assign o_div   = r_div;
    assign o_rem   = r_rem;
    assign o_dq    = r_dq;

endmodule

// ===== hdl/uvs_taylor_cell.sv =====
// ----------------------------------------------------------------------------
// uvs_taylor_cell
// One Taylor term of sin and cos for both angles: multiply by theta^2,
// divide by the term's constant factorial step, accumulate (sin only while K < TERMS).
// ----------------------------------------------------------------------------
module uvs_taylor_cell
    import uvs_pkg::*;
#(
    parameter int K = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0][31:0]           i_t2,
    input  logic [1:0][1:0][31:0]      i_term,
    input  logic [1:0][1:0][33:0]      i_sum,
    input  t_side                      i_side,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [1:0][31:0]           o_t2,
    output logic [1:0][1:0][31:0]      o_term,
    output logic [1:0][1:0][33:0]      o_sum,
    output t_side                      o_side
);

    localparam int S_DIV = 2*K*(2*K+1);
    localparam int C_DIV = (2*K-1)*(2*K);
    localparam int S_SH  = 30 + $clog2(S_DIV+1);
    localparam int C_SH  = 30 + $clog2(C_DIV+1);
    localparam logic [31:0] S_REC = 32'((64'd1 << S_SH) / S_DIV);
    localparam logic [31:0] C_REC = 32'((64'd1 << C_SH) / C_DIV);
    localparam logic [7:0]  S_D8  = 8'(S_DIV);
    localparam logic [7:0]  C_D8  = 8'(C_DIV);
    localparam bit SIN_ON = (K < TERMS);
    localparam bit SUB    = (K % 2) == 1;

    logic r_v1, r_v2, r_v3;
    logic rdy1, rdy2, rdy3;

    logic [1:0][1:0][31:0] r1_x, n1_x;
    logic [1:0][31:0]      r1_t2;
    logic [1:0][1:0][33:0] r1_sum;
    t_side                 r1_side;

    logic [1:0][1:0][31:0] r2_q, n2_q;
    logic [1:0][1:0][31:0] r2_x;
    logic [1:0][31:0]      r2_t2;
    logic [1:0][1:0][33:0] r2_sum;
    t_side                 r2_side;

    logic [1:0][1:0][31:0] r3_term, n3_term;
    logic [1:0][1:0][33:0] r3_sum, n3_sum;
    logic [1:0][31:0]      r3_t2;
    t_side                 r3_side;

    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            for (int c = 0; c < 2; c++) begin
                n1_x[a][c] = 32'((64'(i_term[a][c]) * 64'(i_t2[a])) >> 30);
            end
        end
    end

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            n2_q[a][SER_SIN] = 32'((64'(r1_x[a][SER_SIN]) * 64'(S_REC)) >> S_SH);
            n2_q[a][SER_COS] = 32'((64'(r1_x[a][SER_COS]) * 64'(C_REC)) >> C_SH);
        end
    end

    always_comb begin
        logic [39:0] v_rem;
        logic [7:0]  v_d;
        logic [31:0] v_q;
        v_rem = '0;
        v_d   = '0;
        v_q   = '0;
        for (int a = 0; a < 2; a++) begin
            for (int c = 0; c < 2; c++) begin
                v_d   = (c == SER_SIN) ? S_D8 : C_D8;
                v_rem = 40'(r2_x[a][c]) - 40'(r2_q[a][c]) * 40'(v_d);
                v_q   = (v_rem >= 40'(v_d)) ? r2_q[a][c] + 32'd1 : r2_q[a][c];
                n3_term[a][c] = v_q;
                if (c == SER_SIN && !SIN_ON) begin
                    n3_sum[a][c] = r2_sum[a][c];
                end else if (SUB) begin
                    n3_sum[a][c] = r2_sum[a][c] - 34'(v_q);
                end else begin
                    n3_sum[a][c] = r2_sum[a][c] + 34'(v_q);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && rdy1) begin
            r1_x    <= n1_x;
            r1_t2   <= i_t2;
            r1_sum  <= i_sum;
            r1_side <= i_side;
        end
        if (r_v1 && rdy2) begin
            r2_q    <= n2_q;
            r2_x    <= r1_x;
            r2_t2   <= r1_t2;
            r2_sum  <= r1_sum;
            r2_side <= r1_side;
        end
        if (r_v2 && rdy3) begin
            r3_term <= n3_term;
            r3_sum  <= n3_sum;
            r3_t2   <= r2_t2;
            r3_side <= r2_side;
        end
    end

    assign o_valid = r_v3;
    assign o_t2    = r3_t2;
    assign o_term  = r3_term;
    assign o_sum   = r3_sum;
    assign o_side  = r3_side;

endmodule

// ===== hdl/uv_sphere_vertex_generator.sv =====
// Path: division cells for NSTEP = max(ANGLE_BITS, 16) + 1 quotient bits,
// then the theta and theta^2 registers, the Taylor cells and the output registers.
// Throughput: one vertex per cycle; every stage stalls only when full.
// Reset: synchronous active low; clears all stage valids, slices goes to 48.
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator
// UV sphere grid point to unit vertex and texture coordinates: a chain of
// division cells, theta setup, a chain of Taylor cells and the output math.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator
    import uvs_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_ring_row,
    input  logic [7:0]  i_slice_col,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [15:0] o_pos_x,
    output logic signed [15:0] o_pos_y,
    output logic signed [15:0] o_pos_z,
    output logic [16:0] o_tex_s,
    output logic [16:0] o_tex_t,
    output logic        o_out_of_range
);

    localparam int NSTEP = ((ANGLE_BITS > 16) ? ANGLE_BITS : 16) + 1;
    localparam int DW    = NSTEP + 8;
    localparam logic REG_SLICES = 1'b0;
    localparam logic [1:0] QUAD_1 = 2'd0;
    localparam logic [1:0] QUAD_2 = 2'd1;
    localparam logic [1:0] QUAD_3 = 2'd2;
    localparam logic [1:0] QUAD_4 = 2'd3;

    function automatic logic signed [18:0] rnd15(input logic signed [33:0] v);
        logic [33:0] m;
        logic [18:0] r;
        m = v[33] ? 34'(-v) : 34'(v);
        r = 19'((m + 34'd16384) >> 15);
        return v[33] ? (19'd0 - r) : r;
    endfunction

    function automatic logic [15:0] sat16(input logic signed [18:0] v);
        if (v > 19'sd32767) begin
            return 16'h7FFF;
        end else if (v < -19'sd32768) begin
            return 16'h8000;
        end else begin
            return v[15:0];
        end
    endfunction

    function automatic logic [30:0] clamp01(input logic [33:0] v);
        if (v[33]) begin
            return 31'd0;
        end else if (v > 34'(ONE_Q30)) begin
            return ONE_Q30[30:0];
        end else begin
            return v[30:0];
        end
    endfunction

    // configuration
    logic [7:0] r_slices;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slices <= SLICES_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_SLICES) begin
            r_slices <= pwdata[7:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SLICES) ? {24'd0, r_slices} : 32'd0;

    // division chain
    logic [NSTEP:0]                        c_valid;
    logic [NSTEP:0]                        c_ready;
    logic [NSTEP:0]                        c_oor;
    logic [NSTEP:0][7:0]                   c_div;
    logic [NSTEP:0][LANES-1:0][7:0]        c_rem;
    logic [NSTEP:0][LANES-1:0][NSTEP-1:0]  c_dq;

    always_comb begin
        logic [LANES-1:0][DW-1:0] v_dvd;
        logic [7:0]               v_half;
        v_half = r_slices >> 1;
        v_dvd[LANE_POL] = (DW'(i_ring_row) << (ANGLE_BITS-1)) + DW'(v_half);
        v_dvd[LANE_AZ]  = (DW'(i_slice_col) << ANGLE_BITS) + DW'(v_half);
        v_dvd[LANE_TS]  = (DW'(i_slice_col) << 16) + DW'(v_half);
        v_dvd[LANE_TT]  = (DW'(i_ring_row) << 16) + DW'(v_half);
        for (int l = 0; l < LANES; l++) begin
            c_rem[0][l] = v_dvd[l][DW-1:NSTEP];
            c_dq[0][l]  = v_dvd[l][NSTEP-1:0];
        end
    end

    assign c_valid[0] = i_valid;
    assign o_ready    = c_ready[0];
    assign c_div[0]   = r_slices;
    assign c_oor[0]   = (r_slices == 8'd0) || (i_ring_row > r_slices) ||
                        (i_slice_col > r_slices);

    genvar g;
    for (g = 0; g < NSTEP; g++) begin : g_div
        uvs_div_cell #(.NSTEP(NSTEP)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[g]),
            .o_ready (c_ready[g]),
            .i_oor   (c_oor[g]),
            .i_div   (c_div[g]),
            .i_rem   (c_rem[g]),
            .i_dq    (c_dq[g]),
            .o_valid (c_valid[g+1]),
            .i_ready (c_ready[g+1]),
            .o_oor   (c_oor[g+1]),
            .o_div   (c_div[g+1]),
            .o_rem   (c_rem[g+1]),
            .o_dq    (c_dq[g+1])
        );
    end

    // theta setup
    logic             r_thv, r_t2v;
    logic             rdy_th, rdy_t2;
    logic [1:0][30:0] r_th, n_th, r_th2;
    logic [1:0][31:0] r_t2, n_t2;
    t_side            r_th_side, n_th_side, r_t2_side;

    logic [TERMS:0]                   tc_valid;
    logic [TERMS:0]                   tc_ready;
    logic [TERMS:0][1:0][31:0]        tc_t2;
    logic [TERMS:0][1:0][1:0][31:0]   tc_term;
    logic [TERMS:0][1:0][1:0][33:0]   tc_sum;
    t_side [TERMS:0]                  tc_side;

    always_comb begin
        logic [1:0][ANGLE_BITS-1:0] v_ph;
        v_ph[ANG_POL] = c_dq[NSTEP][LANE_POL][ANGLE_BITS-1:0];
        v_ph[ANG_AZ]  = c_dq[NSTEP][LANE_AZ][ANGLE_BITS-1:0];
        for (int a = 0; a < 2; a++) begin
            n_th[a] = 31'((64'(v_ph[a][ANGLE_BITS-3:0]) * 64'(HALFPI_Q30) +
                          (64'd1 << (ANGLE_BITS-3))) >> (ANGLE_BITS-2));
        end
        n_th_side.oor      = c_oor[NSTEP];
        n_th_side.quad_pol = v_ph[ANG_POL][ANGLE_BITS-1:ANGLE_BITS-2];
        n_th_side.quad_az  = v_ph[ANG_AZ][ANGLE_BITS-1:ANGLE_BITS-2];
        n_th_side.tex_s    = c_dq[NSTEP][LANE_TS][16:0];
        n_th_side.tex_t    = c_dq[NSTEP][LANE_TT][16:0];
    end

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            n_t2[a] = 32'((64'(r_th[a]) * 64'(r_th[a])) >> 30);
        end
    end

    assign rdy_t2         = !r_t2v || tc_ready[0];
    assign rdy_th         = !r_thv || rdy_t2;
    assign c_ready[NSTEP] = rdy_th;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thv <= 1'b0;
            r_t2v <= 1'b0;
        end else begin
            if (rdy_th) r_thv <= c_valid[NSTEP];
            if (rdy_t2) r_t2v <= r_thv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_valid[NSTEP] && rdy_th) begin
            r_th      <= n_th;
            r_th_side <= n_th_side;
        end
        if (r_thv && rdy_t2) begin
            r_t2      <= n_t2;
            r_th2     <= r_th;
            r_t2_side <= r_th_side;
        end
    end

    // Taylor chain
    assign tc_valid[0] = r_t2v;
    assign tc_t2[0]    = r_t2;
    assign tc_side[0]  = r_t2_side;

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            tc_term[0][a][SER_SIN] = {1'b0, r_th2[a]};
            tc_sum[0][a][SER_SIN]  = 34'(r_th2[a]);
            tc_term[0][a][SER_COS] = ONE_Q30;
            tc_sum[0][a][SER_COS]  = 34'(ONE_Q30);
        end
    end

    for (g = 0; g < TERMS; g++) begin : g_tay
        uvs_taylor_cell #(.K(g+1)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (tc_valid[g]),
            .o_ready (tc_ready[g]),
            .i_t2    (tc_t2[g]),
            .i_term  (tc_term[g]),
            .i_sum   (tc_sum[g]),
            .i_side  (tc_side[g]),
            .o_valid (tc_valid[g+1]),
            .i_ready (tc_ready[g+1]),
            .o_t2    (tc_t2[g+1]),
            .o_term  (tc_term[g+1]),
            .o_sum   (tc_sum[g+1]),
            .o_side  (tc_side[g+1])
        );
    end

    // output math
    logic r_f1v, r_f2v, r_ov;
    logic rdy_f1, rdy_f2, rdy_o;
    logic signed [16:0] r_y, r_r, r_ca, r_sa, r_y2;
    logic signed [16:0] n_y, n_r, n_ca, n_sa;
    logic signed [33:0] r_px, r_pz;
    t_side r_f1_side, r_f2_side;
    logic [15:0] r_ox, r_oy, r_oz;
    logic [16:0] r_ots, r_ott;
    logic        r_ooor;

    always_comb begin
        logic [1:0] v_q;
        logic signed [33:0] v_s0, v_c0, v_s, v_c;
        logic signed [18:0] v_r;
        n_y  = '0;
        n_r  = '0;
        n_ca = '0;
        n_sa = '0;
        for (int a = 0; a < 2; a++) begin
            v_q  = (a == ANG_POL) ? tc_side[TERMS].quad_pol : tc_side[TERMS].quad_az;
            v_s0 = 34'(clamp01(tc_sum[TERMS][a][SER_SIN]));
            v_c0 = 34'(clamp01(tc_sum[TERMS][a][SER_COS]));
            case (v_q)
                QUAD_1: begin
                    v_s = v_s0;
                    v_c = v_c0;
                end
                QUAD_2: begin
                    v_s = v_c0;
                    v_c = -v_s0;
                end
                QUAD_3: begin
                    v_s = -v_s0;
                    v_c = -v_c0;
                end
                QUAD_4: begin
                    v_s = -v_c0;
                    v_c = v_s0;
                end
                default: begin
                    v_s = v_s0;
                    v_c = v_c0;
                end
            endcase
            if (a == ANG_POL) begin
                v_r = rnd15(-v_c);
                n_y = v_r[16:0];
                v_r = rnd15(v_s);
                n_r = v_r[16:0];
            end else begin
                v_r  = rnd15(v_c);
                n_ca = v_r[16:0];
                v_r  = rnd15(v_s);
                n_sa = v_r[16:0];
            end
        end
    end

    assign rdy_o  = !r_ov || i_ready;
    assign rdy_f2 = !r_f2v || rdy_o;
    assign rdy_f1 = !r_f1v || rdy_f2;
    assign tc_ready[TERMS] = rdy_f1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1v <= 1'b0;
            r_f2v <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            if (rdy_f1) r_f1v <= tc_valid[TERMS];
            if (rdy_f2) r_f2v <= r_f1v;
            if (rdy_o)  r_ov  <= r_f2v;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [33:0] v_px, v_pz;
        v_px = r_ca * r_r;
        v_pz = r_sa * r_r;
        if (tc_valid[TERMS] && rdy_f1) begin
            r_y       <= n_y;
            r_r       <= n_r;
            r_ca      <= n_ca;
            r_sa      <= n_sa;
            r_f1_side <= tc_side[TERMS];
        end
        if (r_f1v && rdy_f2) begin
            r_px      <= -v_px;
            r_pz      <= v_pz;
            r_y2      <= r_y;
            r_f2_side <= r_f1_side;
        end
        if (r_f2v && rdy_o) begin
            if (r_f2_side.oor) begin
                r_ox  <= '0;
                r_oy  <= '0;
                r_oz  <= '0;
                r_ots <= '0;
                r_ott <= '0;
            end else begin
                r_ox  <= sat16(rnd15(r_px));
                r_oy  <= sat16({{2{r_y2[16]}}, r_y2});
                r_oz  <= sat16(rnd15(r_pz));
                r_ots <= r_f2_side.tex_s;
                r_ott <= r_f2_side.tex_t;
            end
            r_ooor <= r_f2_side.oor;
        end
    end

    assign o_valid        = r_ov;
    assign o_pos_x        = r_ox;
    assign o_pos_y        = r_oy;
    assign o_pos_z        = r_oz;
    assign o_tex_s        = r_ots;
    assign o_tex_t        = r_ott;
    assign o_out_of_range = r_ooor;

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_of_range |-> (o_pos_x == 16'sd0 && o_pos_y == 16'sd0 &&
        o_pos_z == 16'sd0 && o_tex_s == 17'd0 && o_tex_t == 17'd0))
        else $error("out of range result carries nonzero fields");

    a_tex_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out_of_range |-> (o_tex_s <= 17'd65536 && o_tex_t <= 17'd65536))
        else $error("texture coordinate above one");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && paddr[2] == REG_SLICES) |=>
        r_slices == $past(pwdata[7:0]))
        else $error("slices register not written");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input stalled while output side is free");

endmodule
